FILE: rtl/core/distributed_arithmetic_fir_assert.svh
// Assertion macros for the distributed-arithmetic FIR filter.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef DISTRIBUTED_ARITHMETIC_FIR_ASSERT_SVH
`define DISTRIBUTED_ARITHMETIC_FIR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DAFIR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DAFIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/dafir_pkg.sv
// Shared constants and the controller-to-datapath command type of the
// distributed-arithmetic FIR filter. No dependencies.
package dafir_pkg;

  localparam int TAPS          = 8;
  localparam int SAMPLE_BITS   = 16;
  localparam int COEF_BITS     = 16;
  localparam int NUM_COEFS     = 8;
  localparam int IN_BITS       = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int OUT_BITS      = 35;

  localparam int TAP_IDX_BITS  = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int SUM_BITS      = COEF_BITS + TAP_IDX_BITS;
  localparam int TABLE_DEPTH   = 1 << TAPS;
  localparam int PLANE_BITS    = $clog2(SAMPLE_BITS);

  typedef struct packed {
    logic                  shift_in;
    logic                  build_en;
    logic [TAPS-1:0]       build_k;
    logic                  rd_en;
    logic                  rd_first;
    logic [PLANE_BITS-1:0] plane;
    logic                  out_load;
  } dafir_cmd_t;

endpackage

FILE: rtl/core/distributed_arithmetic_fir.sv
// Distributed-arithmetic FIR filter, eight taps, bit-serial. A sample goes
// from acceptance to a result in the output register through an accept
// state, a read of the subset-sum table for each of the sixteen bit planes
// through its single read port, a step to fold in the last plane and one
// to load the output register; a result not yet taken holds the next sample
// off only once the following one is finished. After reset and after every
// coefficient write the 256-entry table is rebuilt in a sweep, one entry
// per cycle, which any coefficient write starts again; in_ready stays low
// meanwhile, and writes are taken at any time. Results keep Q1.15 scaling.
`include "distributed_arithmetic_fir_assert.svh"

module distributed_arithmetic_fir (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [dafir_pkg::IN_BITS-1:0]  in_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [dafir_pkg::OUT_BITS-1:0] out_filtered,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dafir_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [dafir_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import dafir_pkg::*;

  dafir_cmd_t cmd;
  logic       cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  dafir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_we    (cfg_we),
    .cmd       (cmd)
  );

  dafir_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_sample    (in_sample),
    .cmd          (cmd),
    .out_filtered (out_filtered)
  );

  `DAFIR_ASSERT_SAME(a_no_accept_in_build, cmd.build_en, !in_ready, "word accepted during table build")
  `DAFIR_ASSERT_NEXT(a_accept_starts_top, in_valid && in_ready, cmd.rd_en && cmd.rd_first, "sign plane not read first")
  `DAFIR_ASSERT_SAME(a_no_out_overwrite, cmd.out_load, !(out_valid && !out_ready), "pending result overwritten")

endmodule

FILE: rtl/core/dafir_ctrl.sv
// Controller of the distributed-arithmetic FIR filter: table rebuild sweep,
// bit-plane sequencing and the output handshake. Depends on dafir_pkg.
module dafir_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  cfg_we,
  output dafir_pkg::dafir_cmd_t cmd
);
  import dafir_pkg::*;

  typedef enum logic [2:0] {
    S_BUILD,
    S_IDLE,
    S_RUN,
    S_FIN,
    S_OUT
  } state_t;

  localparam logic [PLANE_BITS-1:0] PLANE_TOP  = PLANE_BITS'(SAMPLE_BITS - 1);
  localparam logic [TAPS-1:0]       BUILD_LAST = {TAPS{1'b1}};

  state_t                state_r;
  logic [TAPS-1:0]       build_k_r;
  logic [PLANE_BITS-1:0] plane_r;
  logic                  pend_r;
  logic                  pend_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic                  out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && !pend_r;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.shift_in = in_valid && in_ready;
    cmd.build_en = (state_r == S_BUILD);
    cmd.build_k  = build_k_r;
    cmd.rd_en    = (state_r == S_RUN);
    cmd.rd_first = (plane_r == PLANE_TOP);
    cmd.plane    = plane_r;
    cmd.out_load = (state_r == S_OUT) && out_free;
  end

  // A coefficient write leaves a rebuild pending, unless the sweep is
  // starting over in this cycle anyway.
  always_comb begin
    pend_nxt = pend_r || cfg_we;
    if ((state_r == S_BUILD) || ((state_r == S_IDLE) && pend_r)) begin
      pend_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r && !out_ready;
    if ((state_r == S_OUT) && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Reset starts a build sweep, which also clears the table memory.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_BUILD;
      build_k_r   <= '0;
      plane_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      case (state_r)
        S_BUILD: begin
          // A coefficient write during the sweep starts it again.
          if (cfg_we) begin
            build_k_r <= '0;
          end else if (build_k_r == BUILD_LAST) begin
            state_r <= S_IDLE;
          end else begin
            build_k_r <= build_k_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (pend_r) begin
            state_r   <= S_BUILD;
            build_k_r <= '0;
          end else if (in_valid) begin
            state_r <= S_RUN;
            plane_r <= PLANE_TOP;
          end
        end
        S_RUN: begin
          if (plane_r == '0) begin
            state_r <= S_FIN;
          end else begin
            plane_r <= plane_r - 1'b1;
          end
        end
        S_FIN: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_BUILD;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/dafir_dp.sv
// Datapath of the distributed-arithmetic FIR filter: coefficient registers,
// delay line, subset-sum table memory and accumulator. Depends on dafir_pkg.
module dafir_dp (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        cfg_we,
  input  logic [dafir_pkg::CFG_IDX_BITS-1:0]          cfg_index,
  input  logic [dafir_pkg::CFG_DATA_BITS-1:0]         cfg_data,
  input  logic signed [dafir_pkg::IN_BITS-1:0]        in_sample,
  input  dafir_pkg::dafir_cmd_t                       cmd,
  output logic signed [dafir_pkg::OUT_BITS-1:0]       out_filtered
);
  import dafir_pkg::*;

  logic [CFG_DATA_BITS-1:0]   coef_r [NUM_COEFS];
  logic [SAMPLE_BITS-1:0]     taps_r [TAPS];
  logic [SUM_BITS-1:0]        table_mem [TABLE_DEPTH];
  logic signed [SUM_BITS-1:0] sum_r;
  logic signed [SUM_BITS-1:0] sum_nxt;
  logic signed [SUM_BITS-1:0] coef_w;
  logic [SUM_BITS-1:0]        rd_data_r;
  logic                       acc_en_r;
  logic                       acc_first_r;
  logic signed [OUT_BITS-1:0] acc_r;
  logic signed [OUT_BITS-1:0] acc_nxt;
  logic signed [OUT_BITS-1:0] part;
  logic signed [OUT_BITS-1:0] out_r;
  logic [TAPS-1:0]            gray;
  logic [TAP_IDX_BITS-1:0]    flip_bit;
  logic [TAPS-1:0]            rd_addr;

  // The sweep visits table entries in Gray-code order, so each entry differs
  // from the previous one by a single coefficient added or taken away.
  always_comb begin
    gray     = cmd.build_k ^ (cmd.build_k >> 1);
    flip_bit = '0;
    for (int i = TAPS - 1; i >= 0; i--) begin
      if (cmd.build_k[i]) begin
        flip_bit = TAP_IDX_BITS'(i);
      end
    end
    coef_w = SUM_BITS'(signed'(COEF_BITS'(signed'(coef_r[flip_bit]))));
    if (cmd.build_k == '0) begin
      sum_nxt = '0;
    end else if (gray[flip_bit]) begin
      sum_nxt = sum_r + coef_w;
    end else begin
      sum_nxt = sum_r - coef_w;
    end
  end

  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      rd_addr[i] = taps_r[i][cmd.plane];
    end
  end

  // Planes arrive sign plane first, so the sum is built by doubling.
  assign part    = OUT_BITS'(signed'(rd_data_r));
  assign acc_nxt = acc_first_r ? -part : (acc_r <<< 1) + part;

  always_ff @(posedge clk) begin
    if (cmd.build_en) begin
      table_mem[gray] <= sum_nxt;
    end
    if (cmd.rd_en) begin
      rd_data_r <= table_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef_r[i] <= '0;
      end
      for (int i = 0; i < TAPS; i++) begin
        taps_r[i] <= '0;
      end
      acc_en_r    <= 1'b0;
      acc_first_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        coef_r[cfg_index] <= cfg_data;
      end
      if (cmd.shift_in) begin
        taps_r[0] <= SAMPLE_BITS'(signed'(in_sample));
        for (int i = 1; i < TAPS; i++) begin
          taps_r[i] <= taps_r[i-1];
        end
      end
      acc_en_r    <= cmd.rd_en;
      acc_first_r <= cmd.rd_first;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.build_en) begin
      sum_r <= sum_nxt;
    end
    if (acc_en_r) begin
      acc_r <= acc_nxt;
    end
    if (cmd.out_load) begin
      out_r <= acc_r;
    end
  end

  assign out_filtered = out_r;

endmodule
